// ===== hw/rtl/cbh_pkg.sv =====
// Shared types and constants for the CubeHash byte-stream hasher.
// No dependencies; used by the controller, the datapath and the top level.
package cbh_pkg;

   localparam int ROUNDS          = 8;
   localparam int NUM_WORDS       = 32;
   localparam int INIT_TRANSFORMS = 10;
   localparam int LONG_ROUNDS     = INIT_TRANSFORMS * ROUNDS;
   localparam int CTR_W           = $clog2(LONG_ROUNDS + 1);
   localparam int LEN_W           = 7;
   localparam int IDX_W           = 6;

   localparam logic [LEN_W-1:0] LEN_MIN   = 7'd1;
   localparam logic [LEN_W-1:0] LEN_MAX   = 7'd64;
   localparam logic [7:0]       PAD_BYTE  = 8'h80;

   typedef logic [31:0] word_type;

   // Commands from the controller to the datapath for one cycle.
   typedef struct packed {
      logic             load;      // load the initial words
      logic [LEN_W-1:0] load_len;  // digest length placed in word 0
      logic             step;      // run one round
      logic [7:0]       inject;    // XOR into low byte of word 0 before the round
      logic             flip;      // XOR 1 into word 31 before the round
   } cmd_type;

endpackage

// ===== hw/rtl/cbh_datapath.sv =====
// Datapath of the CubeHash hasher: the 32-word state and one round per cycle while cmd.step is set.
// Depends on cbh_pkg for the command struct and constants.
module cbh_datapath
   import cbh_pkg::*;
(
   input  logic             clock,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] emit_idx,
   output logic [7:0]       sel_byte
);

   word_type st_ff [NUM_WORDS];
   word_type st_in [NUM_WORDS];

   word_type a0 [16];
   word_type b0 [16];
   word_type b1 [16];
   word_type a2 [16];
   word_type b2 [16];
   word_type a3 [16];
   word_type rd_word;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // One CubeHash round on the state, with the pending injections applied first.
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         a0[k] = st_ff[k];
         b0[k] = st_ff[k + 16];
      end
      a0[0]  = st_ff[0] ^ {24'd0, cmd.inject};
      b0[15] = st_ff[31] ^ {31'd0, cmd.flip};
      for (int k = 0; k < 16; k++) begin
         b1[k] = b0[k] + a0[k];
      end
      for (int k = 0; k < 16; k++) begin
         a2[k] = rotl(a0[4'(k) ^ 4'h8], 7) ^ b1[k];
      end
      for (int k = 0; k < 16; k++) begin
         b2[k] = b1[4'(k) ^ 4'h2] + a2[k];
      end
      for (int k = 0; k < 16; k++) begin
         a3[k] = rotl(a2[4'(k) ^ 4'h4], 11) ^ b2[k];
      end
      for (int k = 0; k < 16; k++) begin
         st_in[k]      = st_ff[k];
         st_in[k + 16] = st_ff[k + 16];
      end
      if (cmd.load) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            st_in[k] = '0;
         end
         st_in[0] = {25'd0, cmd.load_len};
         st_in[1] = 32'd1;
         st_in[2] = 32'(ROUNDS);
      end else if (cmd.step) begin
         for (int k = 0; k < 16; k++) begin
            st_in[k]      = a3[k];
            st_in[k + 16] = b2[4'(k) ^ 4'h1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   // Digest bytes come from the low words, least significant byte first.
   always_comb begin
      rd_word  = st_ff[{1'b0, emit_idx[IDX_W-1:2]}];
      sel_byte = 8'(rd_word >> {emit_idx[1:0], 3'b000});
   end

endmodule

// ===== hw/rtl/cbh_ctrl.sv =====
// Controller of the CubeHash hasher: sequencing state machine, digest length
// register and the result output register. Depends on cbh_pkg.
module cbh_ctrl
   import cbh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_action,
   input  logic [7:0]       req_byte,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_byte,
   output logic             rsp_last,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] emit_idx,
   input  logic [7:0]       sel_byte
);

   typedef enum logic [2:0] {
      S_INIT,
      S_WARM,
      S_IDLE,
      S_ABSORB,
      S_FIN1,
      S_FIN2,
      S_EMIT
   } state_type;

   localparam logic [CTR_W-1:0] CTR_TRANSFORM = CTR_W'(ROUNDS - 1);
   localparam logic [CTR_W-1:0] CTR_LONG      = CTR_W'(LONG_ROUNDS);
   localparam logic [CTR_W-1:0] CTR_ONE       = CTR_W'(1);

   state_type        state_ff, state_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             vld_ff, vld_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             accept;
   logic             out_free;
   logic             is_last;

   // A register write restarts the initial load, so no request is taken in
   // the same cycle; it waits for the reload to finish.
   assign req_tready = (state_ff == S_IDLE) && !csr_we;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !vld_ff || rsp_tready;
   assign is_last    = ({1'b0, idx_ff} == (len_ff - LEN_MIN));
   assign emit_idx   = idx_ff;
   assign rsp_tvalid = vld_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_last   = last_ff;

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      vld_in       = vld_ff && !rsp_tready;
      byte_in      = byte_ff;
      last_in      = last_ff;
      cmd          = '0;
      cmd.load_len = len_ff;

      case (state_ff)
         S_INIT: begin
            cmd.load = 1'b1;
            ctr_in   = CTR_LONG;
            state_in = S_WARM;
         end
         S_WARM: begin
            cmd.step = 1'b1;
            ctr_in   = ctr_ff - CTR_ONE;
            if (ctr_ff == CTR_ONE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.step   = 1'b1;
               cmd.inject = req_action ? PAD_BYTE : req_byte;
               ctr_in     = CTR_TRANSFORM;
               if (req_action) begin
                  if (ROUNDS > 1) begin
                     state_in = S_FIN1;
                  end else begin
                     ctr_in   = CTR_LONG;
                     state_in = S_FIN2;
                  end
               end else if (ROUNDS > 1) begin
                  state_in = S_ABSORB;
               end
            end
         end
         S_ABSORB: begin
            cmd.step = 1'b1;
            ctr_in   = ctr_ff - CTR_ONE;
            if (ctr_ff == CTR_ONE) begin
               state_in = S_IDLE;
            end
         end
         S_FIN1: begin
            cmd.step = 1'b1;
            ctr_in   = ctr_ff - CTR_ONE;
            if (ctr_ff == CTR_ONE) begin
               ctr_in   = CTR_LONG;
               state_in = S_FIN2;
            end
         end
         S_FIN2: begin
            cmd.step = 1'b1;
            cmd.flip = (ctr_ff == CTR_LONG);
            ctr_in   = ctr_ff - CTR_ONE;
            if (ctr_ff == CTR_ONE) begin
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               vld_in  = 1'b1;
               byte_in = sel_byte;
               last_in = is_last;
               idx_in  = idx_ff + IDX_W'(1);
               if (is_last) begin
                  state_in = S_INIT;
               end
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      // A register write saturates the length and restarts the initial load.
      if (csr_we) begin
         if (csr_wdata < LEN_MIN) begin
            len_in = LEN_MIN;
         end else if (csr_wdata > LEN_MAX) begin
            len_in = LEN_MAX;
         end else begin
            len_in = csr_wdata;
         end
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ctr_ff   <= '0;
         idx_ff   <= '0;
         len_ff   <= LEN_MAX;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctr_ff   <= ctr_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         vld_ff   <= vld_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

// ===== hw/rtl/cubehash_byte_stream_hasher.sv =====
// Top level of the CubeHash byte-stream hasher (8 rounds per one-byte block).
// Depends on cbh_pkg, cbh_ctrl and cbh_datapath.
//
// Usage: each request on the req_ channel carries one message byte in
// req_tdata and an action flag in req_tuser. With req_tuser low the byte is
// absorbed; with req_tuser high the message is finished and the digest is
// returned on the rsp_ channel, one byte per transfer starting with the low
// byte of word 0, with rsp_tlast on the final byte.
// The csr_ port writes the digest length in bytes (1 to 64; 0 reads as 1 and
// larger values as 64). A write reloads the initial state and drops any
// message absorbed so far; it is meant to be issued while the block is idle.
// Timing: the 1024-bit state is updated by one round per clock cycle while
// rounds are running; an absorb request occupies the block for a whole
// transform. A finish request runs one transform and then ten more before
// the first digest byte is presented, then one digest byte per cycle while
// rsp_tready stays high. After the last byte leaves the emit sequence the
// initial value is recomputed (a load step plus ten transforms) before
// req_tready rises again. Reset, synchronous and active high, sets the length
// to 64 and starts the same reload; req_tready stays low until it completes.
// When the receiver stalls, the current digest byte is held in the output
// register and the emit sequence waits; nothing is dropped.
module cubehash_byte_stream_hasher
   import cbh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // Configuration write: digest length in bytes.
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata,
   // Request channel.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tuser,   // [0] action (1 finishes the message)
   // Result channel.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] digest_byte
   output logic             rsp_tlast    // last_byte
);

   cmd_type          cmd;
   logic [IDX_W-1:0] emit_idx;
   logic [7:0]       sel_byte;

   // The controller sequences rounds and output bytes; the datapath holds
   // the state words and applies one round whenever it is told to.
   cbh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_byte   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .cmd        (cmd),
      .emit_idx   (emit_idx),
      .sel_byte   (sel_byte)
   );

   cbh_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .emit_idx (emit_idx),
      .sel_byte (sel_byte)
   );

endmodule

// ===== verif/cubehash_byte_stream_hasher_tb.sv =====
// Self-checking testbench for the CubeHash byte-stream hasher.
// Depends on cbh_pkg and the cubehash_byte_stream_hasher top level; it keeps
// its own CubeHash model and checks every digest byte that comes back.
module cubehash_byte_stream_hasher_tb
   import cbh_pkg::*;
();

   // Action flag carried in req_tuser.
   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // Ways in which the receiver stalls the result channel.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // The block must finish rebuilding its initial value or absorbing a byte
   // before it is idle, and this many quiet cycles guarantee that it is.
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_ITEMS  = 145;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [7:0] digest_byte;
      logic       last_byte;
   } digest_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;   // [7:0] data_byte
   logic             req_tuser = 1'b0; // [0] action
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // [7:0] digest_byte
   logic             rsp_tlast;        // last_byte

   cubehash_byte_stream_hasher uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Digest predictor: its own copy of the 1024-bit state and the length.
   // ------------------------------------------------------------------
   word_type         cube_words [NUM_WORDS];
   logic [LEN_W-1:0] digest_len;
   digest_item_type  digest_queue [$];

   int error_count = 0;
   int cycle_count = 0;
   int burst_left  = 0;

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // One CubeHash round over the two 16-word halves of the state.
   task automatic cube_round();
      word_type t [16];
      for (int k = 0; k < 16; k++) cube_words[k + 16] += cube_words[k];
      for (int k = 0; k < 16; k++) t[k ^ 8] = cube_words[k];
      for (int k = 0; k < 16; k++) cube_words[k] = rotl(t[k], 7) ^ cube_words[k + 16];
      for (int k = 0; k < 16; k++) t[k ^ 2] = cube_words[k + 16];
      for (int k = 0; k < 16; k++) cube_words[k + 16] = t[k] + cube_words[k];
      for (int k = 0; k < 16; k++) t[k ^ 4] = cube_words[k];
      for (int k = 0; k < 16; k++) cube_words[k] = rotl(t[k], 11) ^ cube_words[k + 16];
      for (int k = 0; k < 16; k++) t[k ^ 1] = cube_words[k + 16];
      for (int k = 0; k < 16; k++) cube_words[k + 16] = t[k];
   endtask

   task automatic cube_transform();
      repeat (ROUNDS) cube_round();
   endtask

   // The initial value depends on the digest length and takes ten transforms.
   task automatic load_cube_iv();
      foreach (cube_words[k]) cube_words[k] = '0;
      cube_words[0] = word_type'(digest_len);
      cube_words[1] = 32'd1;
      cube_words[2] = ROUNDS;
      repeat (INIT_TRANSFORMS) cube_transform();
   endtask

   // The register saturates: zero becomes the minimum, anything above 64
   // becomes the maximum.
   task automatic set_digest_len(input logic [LEN_W-1:0] value);
      if (value < LEN_MIN) digest_len = LEN_MIN;
      else if (value > LEN_MAX) digest_len = LEN_MAX;
      else digest_len = value;
      load_cube_iv();
   endtask

   // Update the model for one accepted request and queue the digest bytes a
   // finish produces, little-endian from word 0.
   task automatic predict_digest(input logic action, input logic [7:0] data);
      digest_item_type item;
      if (action == ACT_ABSORB) begin
         cube_words[0][7:0] ^= data;
         cube_transform();
      end else begin
         cube_words[0][7:0] ^= PAD_BYTE;
         cube_transform();
         cube_words[NUM_WORDS-1] ^= 32'd1;
         repeat (INIT_TRANSFORMS) cube_transform();
         for (int i = 0; i < digest_len; i++) begin
            item.digest_byte = cube_words[i >> 2][8 * (i % 4) +: 8];
            item.last_byte   = (i + 1 == digest_len);
            digest_queue.push_back(item);
         end
         load_cube_iv();
      end
   endtask

   // ------------------------------------------------------------------
   // Result checking: every accepted digest byte is matched against the
   // oldest expected byte. Values are sampled at the clock edge, before
   // the block updates its outputs.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_digest
      digest_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest byte: expected none, actual byte %02h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = digest_queue.pop_front();
            if (rsp_tdata !== want.digest_byte || rsp_tlast !== want.last_byte) begin
               $display("%0t: digest mismatch: expected byte %02h last %0b, actual byte %02h last %0b",
                        $time, want.digest_byte, want.last_byte, rsp_tdata, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure. Every so often a new stall mode is picked:
   // always ready, mostly ready, a fixed periodic stall, or mostly stalled.
   // Mode lengths vary so that stalls land on every digest byte position.
   // ------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 90);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_LIGHT: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         STALL_PERIODIC: begin
            rsp_tready <= (cycle_count % 5 != 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request sender. Requests go out in bursts of random length; between
   // bursts req_tvalid may drop for a random gap. A request that follows
   // another inside a burst keeps req_tvalid high without a dip.
   // ------------------------------------------------------------------
   task automatic send_request(input logic action, input logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 10);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      predict_digest(action, data);
      burst_left--;
   endtask

   // Hold off new requests until every expected digest byte has arrived.
   // At least one edge passes with req_tvalid low.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // Length writes happen only on an idle block: results drained, then
   // enough quiet cycles for any absorb or reload still in flight.
   task automatic write_digest_length(input logic [LEN_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      set_digest_len(value);
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Default 64-byte digest after reset: the empty message and single-byte
   // messages with the extreme byte values.
   task automatic test_reset_length();
      send_request(ACT_FINISH, 8'h5A);
      send_request(ACT_ABSORB, 8'h00);
      send_request(ACT_FINISH, 8'hFF);
      send_request(ACT_ABSORB, 8'hFF);
      send_request(ACT_FINISH, 8'h00);
   endtask

   // A message with assorted byte patterns, then two finishes in a row so
   // the second hashes the empty message on a freshly reloaded state.
   task automatic test_byte_patterns();
      logic [7:0] pattern [6] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
      foreach (pattern[i]) send_request(ACT_ABSORB, pattern[i]);
      send_request(ACT_FINISH, 8'h80);
      send_request(ACT_FINISH, 8'h7F);
   endtask

   // Saturation of the length register at both ends, plus the minimum.
   task automatic test_length_limits();
      logic [LEN_W-1:0] lengths [4] = '{7'd0, 7'd127, 7'd65, LEN_MIN};
      foreach (lengths[i]) begin
         write_digest_length(lengths[i]);
         send_request(ACT_ABSORB, 8'(i * 8'h3C));
         send_request(ACT_FINISH, 8'h00);
      end
   endtask

   // A length write in the middle of a message throws away what was
   // absorbed; the next message starts from the new initial value.
   task automatic test_dropped_message();
      send_request(ACT_ABSORB, 8'hC3);
      send_request(ACT_ABSORB, 8'h3C);
      write_digest_length(LEN_MAX);
      send_request(ACT_ABSORB, 8'h96);
      send_request(ACT_FINISH, 8'h69);
   endtask

   // Random messages over a series of digest lengths. Most traffic is whole
   // messages (absorbs followed by a finish); the rest is loose requests of
   // either kind, which also leaves partial messages for a length write to
   // discard.
   task automatic test_random_messages();
      int               sent;
      int               phase_items;
      int               msg_len;
      logic [LEN_W-1:0] len_choice;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: len_choice = LEN_MAX;
            1: len_choice = LEN_MIN;
            2: len_choice = 7'd0;
            3: len_choice = 7'd127;
            default: len_choice = LEN_W'($urandom_range(0, 127));
         endcase
         write_digest_length(len_choice);
         phase_items = 0;
         while (phase_items < 24 && sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(0, 6);
               repeat (msg_len) send_request(ACT_ABSORB, 8'($urandom_range(0, 255)));
               send_request(ACT_FINISH, 8'($urandom_range(0, 255)));
               phase_items += msg_len + 1;
               sent        += msg_len + 1;
            end else begin
               send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
               phase_items++;
               sent++;
            end
         end
         // Now and then let the whole pipeline empty before going on.
         if ($urandom_range(0, 2) == 0) drain_results();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence. Reset is held high at the start; the block then rebuilds
   // its initial value on its own, and the first request simply waits for
   // req_tready.
   // ------------------------------------------------------------------
   initial begin
      digest_len = LEN_MAX;
      load_cube_iv();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length();
      test_byte_patterns();
      test_length_limits();
      test_dropped_message();
      test_random_messages();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cbh_pkg.sv
hw/rtl/cbh_datapath.sv
hw/rtl/cbh_ctrl.sv
hw/rtl/cubehash_byte_stream_hasher.sv
verif/cubehash_byte_stream_hasher_tb.sv
